// ===== rtl/ufp_pkg.sv =====
// ----------------------------------------------------------------------------
// ufp_pkg
// shared types and constants of the recognition frame parser
// ----------------------------------------------------------------------------
package ufp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAILER_BYTE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_NEEDED  = 3'd4;

  localparam logic [BYTE_W-1:0] RST_HEADER_FIRST    = 8'd170;
  localparam logic [BYTE_W-1:0] RST_HEADER_SECOND   = 8'd85;
  localparam logic [BYTE_W-1:0] RST_TRAILER_BYTE    = 8'd13;
  localparam logic [BYTE_W-1:0] RST_SCORE_THRESHOLD = 8'd50;
  localparam logic [BYTE_W-1:0] RST_CONFIRM_NEEDED  = 8'd3;

  localparam logic [BYTE_W-1:0] COUNT_MAX = 8'd255;

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HUNT2 = 3'd1,
    PH_CLASS = 3'd2,
    PH_SCORE = 3'd3,
    PH_CHECK = 3'd4,
    PH_TAIL  = 3'd5
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header_first;
    logic [BYTE_W-1:0] header_second;
    logic [BYTE_W-1:0] trailer_byte;
    logic [BYTE_W-1:0] score_threshold;
    logic [BYTE_W-1:0] confirm_needed;
  } cfg_regs_t;

  typedef struct packed {
    logic              good;
    logic [BYTE_W-1:0] frame_class;
    logic [BYTE_W-1:0] frame_score;
  } frame_t;

endpackage

// ===== rtl/ufp_if.sv =====
// ----------------------------------------------------------------------------
// ufp_if
// valid/ready channels of the recognition frame parser
// ----------------------------------------------------------------------------
interface ufp_in_if;
  import ufp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ufp_out_if;
  import ufp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_class;
  logic [BYTE_W-1:0] frame_score;
  logic [BYTE_W-1:0] confirm_count;
  logic              stable_valid;
  logic [BYTE_W-1:0] stable_class;
  logic [BYTE_W-1:0] stable_cnt;
  modport source (output valid, output frame_class, output frame_score,
                  output confirm_count, output stable_valid, output stable_class,
                  output stable_cnt, input ready);
  modport sink   (input valid, input frame_class, input frame_score,
                  input confirm_count, input stable_valid, input stable_class,
                  input stable_cnt, output ready);
endinterface

interface ufp_cfg_if;
  import ufp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [BYTE_W-1:0]    wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== rtl/ufp_regs.sv =====
// ----------------------------------------------------------------------------
// ufp_regs
// configuration register file, one write beat per cycle
// ----------------------------------------------------------------------------
module ufp_regs
  import ufp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  ufp_cfg_if.sink       cfg_ch,
  output cfg_regs_t     regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  assign cfg_ch.ready = 1'b1;
  assign regs         = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        CFG_HEADER_FIRST:    regs_nxt.header_first    = cfg_ch.wdata;
        CFG_HEADER_SECOND:   regs_nxt.header_second   = cfg_ch.wdata;
        CFG_TRAILER_BYTE:    regs_nxt.trailer_byte    = cfg_ch.wdata;
        CFG_SCORE_THRESHOLD: regs_nxt.score_threshold = cfg_ch.wdata;
        CFG_CONFIRM_NEEDED:  regs_nxt.confirm_needed  = cfg_ch.wdata;
        default:             regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.header_first    <= RST_HEADER_FIRST;
      regs_r.header_second   <= RST_HEADER_SECOND;
      regs_r.trailer_byte    <= RST_TRAILER_BYTE;
      regs_r.score_threshold <= RST_SCORE_THRESHOLD;
      regs_r.confirm_needed  <= RST_CONFIRM_NEEDED;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// ===== rtl/ufp_parser.sv =====
// ----------------------------------------------------------------------------
// ufp_parser
// input byte register and frame assembly state machine
// ----------------------------------------------------------------------------
module ufp_parser
  import ufp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ufp_in_if.sink    in_ch,
  input  cfg_regs_t regs,
  input  logic      out_free,
  output frame_t    frame
);

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              adv;

  phase_t            phase_r;
  phase_t            phase_nxt;
  logic [BYTE_W-1:0] held_class_r;
  logic [BYTE_W-1:0] held_score_r;
  logic [BYTE_W-1:0] held_check_r;

  assign adv         = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ch.valid && in_ch.ready) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (adv) begin
      case (phase_r)
        PH_HUNT2: begin
          if (s1_byte_r == regs.header_second) begin
            phase_nxt = PH_CLASS;
          end else if (s1_byte_r == regs.header_first) begin
            phase_nxt = PH_HUNT2;
          end else begin
            phase_nxt = PH_HUNT1;
          end
        end
        PH_CLASS: phase_nxt = PH_SCORE;
        PH_SCORE: phase_nxt = PH_CHECK;
        PH_CHECK: phase_nxt = PH_TAIL;
        PH_TAIL:  phase_nxt = PH_HUNT1;
        default: begin
          phase_nxt = (s1_byte_r == regs.header_first) ? PH_HUNT2 : PH_HUNT1;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    frame.frame_class = held_class_r;
    frame.frame_score = held_score_r;
    case (phase_r)
      PH_TAIL: begin
        frame.good = adv && (s1_byte_r == regs.trailer_byte) &&
                     ((held_class_r ^ held_score_r) == held_check_r);
      end
      default: frame.good = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT1;
      held_class_r <= '0;
      held_score_r <= '0;
      held_check_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (adv && phase_r == PH_CLASS) begin
        held_class_r <= s1_byte_r;
      end
      if (adv && phase_r == PH_SCORE) begin
        held_score_r <= s1_byte_r;
      end
      if (adv && phase_r == PH_CHECK) begin
        held_check_r <= s1_byte_r;
      end
    end
  end

endmodule

// ===== rtl/ufp_confirm.sv =====
// ----------------------------------------------------------------------------
// ufp_confirm
// confirmation counter, stable class tracking and result register
// ----------------------------------------------------------------------------
module ufp_confirm
  import ufp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  frame_t    frame,
  input  cfg_regs_t regs,
  output logic      out_free,
  ufp_out_if.source out_ch
);

  logic [BYTE_W-1:0] prev_class_r;
  logic [BYTE_W-1:0] prev_class_nxt;
  logic [BYTE_W-1:0] count_r;
  logic [BYTE_W-1:0] count_nxt;
  logic              stable_r;
  logic              stable_nxt;
  logic [BYTE_W-1:0] stable_class_r;
  logic [BYTE_W-1:0] stable_class_nxt;
  logic [BYTE_W-1:0] stable_cnt_r;
  logic [BYTE_W-1:0] stable_cnt_nxt;
  logic              same;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [BYTE_W-1:0] out_class_r;
  logic [BYTE_W-1:0] out_score_r;
  logic [BYTE_W-1:0] out_count_r;
  logic              out_stable_r;
  logic [BYTE_W-1:0] out_stable_class_r;
  logic [BYTE_W-1:0] out_stable_cnt_r;

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    same             = (frame.frame_class == prev_class_r) &&
                       (frame.frame_score >= regs.score_threshold);
    prev_class_nxt   = same ? prev_class_r : frame.frame_class;
    if (!same) begin
      count_nxt = 8'd1;
    end else if (count_r == COUNT_MAX) begin
      count_nxt = count_r;
    end else begin
      count_nxt = count_r + 8'd1;
    end
    stable_nxt       = stable_r;
    stable_class_nxt = stable_class_r;
    stable_cnt_nxt   = stable_cnt_r;
    if (count_nxt >= regs.confirm_needed) begin
      stable_nxt       = 1'b1;
      stable_class_nxt = frame.frame_class;
      stable_cnt_nxt   = count_nxt;
    end
  end

  always_comb begin
    if (frame.good) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_class_r   <= '0;
      count_r        <= '0;
      stable_r       <= 1'b0;
      stable_class_r <= '0;
      stable_cnt_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (frame.good) begin
        prev_class_r   <= prev_class_nxt;
        count_r        <= count_nxt;
        stable_r       <= stable_nxt;
        stable_class_r <= stable_class_nxt;
        stable_cnt_r   <= stable_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame.good) begin
      out_class_r        <= frame.frame_class;
      out_score_r        <= frame.frame_score;
      out_count_r        <= count_nxt;
      out_stable_r       <= stable_nxt;
      out_stable_class_r <= stable_class_nxt;
      out_stable_cnt_r   <= stable_cnt_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.frame_class   = out_class_r;
  assign out_ch.frame_score   = out_score_r;
  assign out_ch.confirm_count = out_count_r;
  assign out_ch.stable_valid  = out_stable_r;
  assign out_ch.stable_class  = out_stable_class_r;
  assign out_ch.stable_cnt    = out_stable_cnt_r;

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r != 8'd0))
    else $error("result beat with zero confirm count");

  a_stable_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stable_r |=> stable_r)
    else $error("stable flag cleared");

  a_good_lands: assert property (@(posedge clk) disable iff (!rst_n)
    frame.good |-> out_free)
    else $error("frame finished while result register is blocked");

  a_stable_count_reached: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stable_r) |-> (out_stable_cnt_r != 8'd0))
    else $error("stable class without a count");

endmodule

// ===== rtl/uart_recognition_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// uart_recognition_frame_parser_top
// serial recognition frame parser with xor checksum and confirmation counter
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                         | beat
//  in_ch    | in  | rx_byte                                         | one byte
//  out_ch   | out | frame_class frame_score confirm_count           | one frame
//           |     | stable_valid stable_class stable_cnt            |
//  cfg_ch   | in  | reg_index wdata                                 | one register
//
//  one byte per cycle when not stalled; a result passes from the tail byte beat
//  through the input byte register, then the result register
//  the single result register sets the rate: a held result stalls bytes only
//  once the input register is also full
//  reset is synchronous, active low; config and state registers return to defaults, no sweep
//  cfg_ch is always ready
// ----------------------------------------------------------------------------
module uart_recognition_frame_parser_top
  import ufp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ufp_in_if.sink    in_ch,
  ufp_out_if.source out_ch,
  ufp_cfg_if.sink   cfg_ch
);

  cfg_regs_t regs;
  frame_t    frame;
  logic      out_free;

  ufp_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .regs   (regs)
  );

  ufp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .regs     (regs),
    .out_free (out_free),
    .frame    (frame)
  );

  ufp_confirm u_confirm (
    .clk      (clk),
    .rst_n    (rst_n),
    .frame    (frame),
    .regs     (regs),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule
